// ===== src/scps_pkg.sv =====
// shared types, constants and helper functions for the crossfade pitch shifter
// no dependencies; used by scps_ctrl, scps_dp and the top level
`default_nettype none

package scps_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int WIDE_BITS      = SAMPLE_BITS + 8;
    localparam int PHASE_FRACTION = 12;
    localparam int CFG_BITS       = 23;
    localparam int CFG_IDX_BITS   = 3;
    localparam int GAIN_ONE       = 65536;
    localparam int CUT_LOW        = 655;
    localparam int CUT_HIGH       = 64880;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PITCH_STEP      = 3'd0,
        REG_DELAY_LENGTH    = 3'd1,
        REG_DELAY_FEEDBACK  = 3'd2,
        REG_DRY_WET         = 3'd3,
        REG_CUTOFF          = 3'd4,
        REG_FILTER_FEEDBACK = 3'd5,
        REG_FILTER_TYPE     = 3'd6,
        REG_OUTPUT_VOLUME   = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // datapath steps for one channel, in execution order
    typedef enum logic [4:0] {
        OP_DRD, OP_DMUL, OP_PWR, OP_TRA, OP_MULA, OP_TRB, OP_MULB, OP_FIN,
        OP_MULR, OP_T, OP_MUL1, OP_F1, OP_MUL2, OP_F2, OP_MULW, OP_WET,
        OP_MULD, OP_MIX, OP_MULV, OP_OUT, OP_NONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ch;
        logic start;
        logic finish;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_busy;
    } t_stat;

    function automatic logic signed [WIDE_BITS-1:0] sat_wide(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd8388607;
        lo = -48'sd8388608;
        if (v > hi) begin
            return 24'sh7FFFFF;
        end else if (v < lo) begin
            return 24'sh800000;
        end
        return v[WIDE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd32767;
        lo = -48'sd32768;
        if (v > hi) begin
            return 16'sh7FFF;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // sin^2 window value from an angle in Q30, degree-9 taylor sine
    function automatic logic [15:0] fade_from_x(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sn;
        logic [63:0] sq;
        logic [63:0] f;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        sn = (x * t) >> 30;
        sq = (sn * sn) >> 30;
        f  = (sq * 64'd65536 + 64'd536870912) >> 30;
        if (f > 64'd65535) begin
            return 16'hFFFF;
        end
        return f[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/scps_ctrl.sv =====
// sequencer for the crossfade pitch shifter: reset clear, per-channel step order
// depends on scps_pkg
`default_nettype none

module scps_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  scps_pkg::t_stat i_stat,
    output scps_pkg::t_cmd  o_cmd
);

    scps_pkg::t_state r_state, n_state;
    scps_pkg::t_op    r_op, n_op;
    logic             r_ch, n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scps_pkg::ST_CLEAR;
            r_op    <= scps_pkg::OP_NONE;
            r_ch    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_ch         = r_ch;
        o_cmd.op     = scps_pkg::OP_NONE;
        o_cmd.ch     = r_ch;
        o_cmd.start  = 1'b0;
        o_cmd.finish = 1'b0;
        o_cmd.clear  = 1'b0;
        o_stall      = 1'b1;
        case (r_state)
            scps_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = scps_pkg::ST_IDLE;
                end
            end
            scps_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = scps_pkg::ST_RUN;
                    n_op        = scps_pkg::OP_DRD;
                    n_ch        = 1'b0;
                end
            end
            scps_pkg::ST_RUN: begin
                o_cmd.op = r_op;
                if (r_op == scps_pkg::OP_OUT) begin
                    if (r_ch) begin
                        n_state = scps_pkg::ST_DONE;
                        n_op    = scps_pkg::OP_NONE;
                    end else begin
                        n_op = scps_pkg::OP_DRD;
                        n_ch = 1'b1;
                    end
                end else begin
                    n_op = scps_pkg::t_op'(r_op + 5'd1);
                end
            end
            scps_pkg::ST_DONE: begin
                // hold the finished pair until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = scps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/scps_dp.sv =====
// datapath: config registers, ring memories, fade table, shared multiplier, filter state
// depends on scps_pkg
`default_nettype none

module scps_dp #(
    parameter int PITCH_DEPTH = 1024,
    parameter int DELAY_DEPTH = 32768
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_wr_en,
    input  wire  [scps_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire  [scps_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  wire  signed [scps_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  wire  signed [scps_pkg::SAMPLE_BITS-1:0] i_right_sample,
    input  scps_pkg::t_cmd                        i_cmd,
    output scps_pkg::t_stat                       o_stat,
    input  wire                                   i_stall,
    output logic                                  o_valid,
    output logic signed [scps_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [scps_pkg::SAMPLE_BITS-1:0] o_right_out
);

    localparam int PW    = $clog2(PITCH_DEPTH);
    localparam int DW    = $clog2(DELAY_DEPTH);
    localparam int PAW   = PW + 1;
    localparam int DAW   = DW + 1;
    localparam int MAXD  = (PITCH_DEPTH > DELAY_DEPTH) ? PITCH_DEPTH : DELAY_DEPTH;
    localparam int CW    = $clog2(2 * MAXD);
    localparam int WB    = scps_pkg::WIDE_BITS;
    localparam int SB    = scps_pkg::SAMPLE_BITS;
    localparam int PF    = scps_pkg::PHASE_FRACTION;
    localparam logic [31:0] PHASE_B_RST = 32'((PITCH_DEPTH / 2) << PF);

    // configuration
    logic [14:0] r_pitch_step;
    logic [14:0] r_delay_len;
    logic [15:0] r_delay_fb;
    logic [16:0] r_dry_wet;
    logic [15:0] r_cutoff;
    logic [22:0] r_filt_fb;
    logic        r_filt_type;
    logic [16:0] r_out_vol;

    // indices and phases
    logic [DW-1:0] r_dwi;
    logic [PW-1:0] r_rwi;
    logic [31:0]   r_phase_a;
    logic [31:0]   r_phase_b;
    logic [CW-1:0] r_clr_cnt;

    // per-channel state
    logic signed [WB-1:0] r_f1 [2];
    logic signed [WB-1:0] r_f2 [2];
    logic signed [WB-1:0] r_pw [2];
    logic signed [SB-1:0] r_x  [2];
    logic signed [SB-1:0] r_res [2];

    // working registers
    logic signed [57:0]   r_prod;
    logic signed [24:0]   r_acc;
    logic signed [WB-1:0] r_fin;
    logic signed [32:0]   r_t;
    logic signed [16:0]   r_wet;
    logic signed [17:0]   r_mix;
    logic [15:0]          r_fade;

    // memories
    logic signed [WB-1:0] pitch_mem [2*PITCH_DEPTH];
    logic signed [WB-1:0] delay_mem [2*DELAY_DEPTH];
    logic signed [WB-1:0] r_pq;
    logic signed [WB-1:0] r_dq;

    logic [15:0] fade_tab [PITCH_DEPTH];

    genvar gk;
    generate
        for (gk = 0; gk < PITCH_DEPTH; gk++) begin : g_fade
            localparam logic [63:0] KF = (2 * gk > PITCH_DEPTH - 1) ?
                                         64'(PITCH_DEPTH - 1 - gk) : 64'(gk);
            localparam logic [63:0] XA = KF * scps_pkg::PI_Q30 / 64'(PITCH_DEPTH - 1);
            assign fade_tab[gk] = scps_pkg::fade_from_x(XA);
        end
    endgenerate

    logic                 ch;
    logic [15:0]          c_clamp;
    logic [16:0]          dw_clamp;
    logic [16:0]          vol_clamp;
    logic [16:0]          dry_gain;
    logic [16:0]          rd_wide;
    logic [DW-1:0]        rd_idx;
    logic [PW-1:0]        ua;
    logic [PW-1:0]        ub;
    logic [PW-1:0]        tap_a;
    logic [PW-1:0]        tap_b;
    logic signed [57:0]   p_sum;
    logic signed [41:0]   p_rnd;
    logic signed [WB-1:0] dsel;
    logic signed [24:0]   fdiff;
    logic signed [33:0]   m_a;
    logic signed [23:0]   m_b;
    logic signed [WB-1:0] f2_new;
    logic signed [41:0]   wet_clip;

    logic                 p_we;
    logic [PAW-1:0]       p_waddr;
    logic signed [WB-1:0] p_wdata;
    logic [PAW-1:0]       p_raddr;
    logic                 d_we;
    logic [DAW-1:0]       d_waddr;
    logic signed [WB-1:0] d_wdata;
    logic [DAW-1:0]       d_raddr;

    always_comb begin
        ch = i_cmd.ch;
        c_clamp = (r_cutoff < 16'(scps_pkg::CUT_LOW))  ? 16'(scps_pkg::CUT_LOW) :
                  (r_cutoff > 16'(scps_pkg::CUT_HIGH)) ? 16'(scps_pkg::CUT_HIGH) : r_cutoff;
        dw_clamp  = (r_dry_wet > 17'(scps_pkg::GAIN_ONE)) ? 17'(scps_pkg::GAIN_ONE) : r_dry_wet;
        vol_clamp = (r_out_vol > 17'(scps_pkg::GAIN_ONE)) ? 17'(scps_pkg::GAIN_ONE) : r_out_vol;
        dry_gain  = 17'(scps_pkg::GAIN_ONE) - dw_clamp;
        rd_wide   = 17'(r_dwi) - {2'b00, r_delay_len};
        rd_idx    = rd_wide[DW-1:0];
        ua        = r_phase_a[PF +: PW];
        ub        = r_phase_b[PF +: PW];
        tap_a     = r_rwi - ua;
        tap_b     = r_rwi - ub;
        // round half up, then drop 16 fraction bits
        p_sum     = r_prod + 58'sd32768;
        p_rnd     = p_sum[57:16];
        // zero delay: the slot read is the one just written with the previous wet
        dsel      = (rd_idx == r_dwi) ? r_pw[ch] : r_dq;
        fdiff     = 25'(r_f1[ch]) - 25'(r_f2[ch]);
        f2_new    = scps_pkg::sat_wide(48'(r_f2[ch]) + 48'(p_rnd));
        wet_clip  = p_rnd;
        if (p_rnd > 42'sd32768) begin
            wet_clip = 42'sd32768;
        end else if (p_rnd < -42'sd32768) begin
            wet_clip = -42'sd32768;
        end

        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            scps_pkg::OP_DMUL: begin
                m_a = 34'(dsel);
                m_b = $signed({8'b0, r_delay_fb});
            end
            scps_pkg::OP_MULA, scps_pkg::OP_MULB: begin
                m_a = 34'(r_pq);
                m_b = $signed({8'b0, r_fade});
            end
            scps_pkg::OP_MULR, scps_pkg::OP_MUL2: begin
                m_a = 34'(fdiff);
                m_b = (i_cmd.op == scps_pkg::OP_MULR) ? $signed({1'b0, r_filt_fb}) :
                                                        $signed({8'b0, c_clamp});
            end
            scps_pkg::OP_MUL1: begin
                m_a = 34'(r_t);
                m_b = $signed({8'b0, c_clamp});
            end
            scps_pkg::OP_MULW: begin
                m_a = 34'(r_pw[ch]);
                m_b = $signed({7'b0, dw_clamp});
            end
            scps_pkg::OP_MULD: begin
                m_a = 34'(r_x[ch]);
                m_b = $signed({7'b0, dry_gain});
            end
            scps_pkg::OP_MULV: begin
                m_a = 34'(r_mix);
                m_b = $signed({7'b0, vol_clamp});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase

        p_we    = 1'b0;
        p_waddr = {ch, r_rwi};
        p_wdata = scps_pkg::sat_wide(48'(r_x[ch]) + 48'(p_rnd));
        p_raddr = {ch, (i_cmd.op == scps_pkg::OP_TRB) ? tap_b : tap_a};
        d_we    = (i_cmd.op == scps_pkg::OP_DMUL);
        d_waddr = {ch, r_dwi};
        d_wdata = r_pw[ch];
        d_raddr = {ch, rd_idx};
        if (i_cmd.op == scps_pkg::OP_PWR) begin
            p_we = 1'b1;
        end
        if (i_cmd.clear) begin
            p_we    = ((r_clr_cnt >> PAW) == '0);
            p_waddr = r_clr_cnt[PAW-1:0];
            p_wdata = '0;
            d_we    = ((r_clr_cnt >> DAW) == '0);
            d_waddr = r_clr_cnt[DAW-1:0];
            d_wdata = '0;
        end

        o_stat.clear_done = &r_clr_cnt;
        o_stat.out_busy   = o_valid && i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            pitch_mem[p_waddr] <= p_wdata;
        end
        r_pq <= pitch_mem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            delay_mem[d_waddr] <= d_wdata;
        end
        r_dq <= delay_mem[d_raddr];
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (i_cmd.start) begin
            r_x[0] <= i_left_sample;
            r_x[1] <= i_right_sample;
        end
        case (i_cmd.op)
            scps_pkg::OP_TRA: r_fade <= fade_tab[ua];
            scps_pkg::OP_TRB: begin
                r_fade <= fade_tab[ub];
                r_acc  <= p_rnd[24:0];
            end
            scps_pkg::OP_FIN: r_fin <= scps_pkg::sat_wide(48'(r_acc) + 48'(p_rnd));
            scps_pkg::OP_T:   r_t   <= 33'(r_fin) - 33'(r_f1[ch]) + p_rnd[32:0];
            scps_pkg::OP_WET: r_wet <= wet_clip[16:0];
            scps_pkg::OP_MIX: r_mix <= 18'($signed(p_rnd[16:0])) + 18'(r_wet);
            scps_pkg::OP_OUT: r_res[ch] <= scps_pkg::sat_sample(48'(p_rnd));
            default: begin
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_step <= '0;
            r_delay_len  <= 15'd5;
            r_delay_fb   <= '0;
            r_dry_wet    <= 17'(scps_pkg::GAIN_ONE);
            r_cutoff     <= 16'(scps_pkg::CUT_HIGH);
            r_filt_fb    <= '0;
            r_filt_type  <= 1'b0;
            r_out_vol    <= 17'(scps_pkg::GAIN_ONE);
            r_dwi        <= '0;
            r_rwi        <= '0;
            r_phase_a    <= '0;
            r_phase_b    <= PHASE_B_RST;
            r_clr_cnt    <= '0;
            r_f1[0]      <= '0;
            r_f1[1]      <= '0;
            r_f2[0]      <= '0;
            r_f2[1]      <= '0;
            r_pw[0]      <= '0;
            r_pw[1]      <= '0;
            o_valid      <= 1'b0;
            o_left_out   <= '0;
            o_right_out  <= '0;
        end else begin
            if (i_cmd.clear && !(&r_clr_cnt)) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_wr_en) begin
                case (scps_pkg::t_cfg_reg'(i_cfg_index))
                    scps_pkg::REG_PITCH_STEP:      r_pitch_step <= i_cfg_data[14:0];
                    scps_pkg::REG_DELAY_LENGTH: begin
                        r_delay_len <= i_cfg_data[14:0];
                        r_dwi       <= '0;
                        r_rwi       <= '0;
                        r_phase_a   <= '0;
                        r_phase_b   <= PHASE_B_RST;
                    end
                    scps_pkg::REG_DELAY_FEEDBACK:  r_delay_fb  <= i_cfg_data[15:0];
                    scps_pkg::REG_DRY_WET:         r_dry_wet   <= i_cfg_data[16:0];
                    scps_pkg::REG_CUTOFF:          r_cutoff    <= i_cfg_data[15:0];
                    scps_pkg::REG_FILTER_FEEDBACK: r_filt_fb   <= i_cfg_data[22:0];
                    scps_pkg::REG_FILTER_TYPE:     r_filt_type <= i_cfg_data[0];
                    scps_pkg::REG_OUTPUT_VOLUME:   r_out_vol   <= i_cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.start) begin
                r_dwi <= r_dwi + 1'b1;
            end
            case (i_cmd.op)
                scps_pkg::OP_F1: r_f1[ch] <= scps_pkg::sat_wide(48'(r_f1[ch]) + 48'(p_rnd));
                scps_pkg::OP_F2: begin
                    r_f2[ch] <= f2_new;
                    r_pw[ch] <= r_filt_type ?
                                scps_pkg::sat_wide(48'(r_fin) - 48'(f2_new)) : f2_new;
                end
                default: begin
                end
            endcase
            if (i_cmd.finish) begin
                o_valid     <= 1'b1;
                o_left_out  <= r_res[0];
                o_right_out <= r_res[1];
                r_phase_a   <= r_phase_a - 32'($signed(r_pitch_step));
                r_phase_b   <= r_phase_b - 32'($signed(r_pitch_step));
                r_rwi       <= r_rwi + 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/stereo_crossfade_pitch_shifter_core.sv =====
// Stereo two-tap crossfade pitch shifter with feedback delay, resonant filter and
// dry/wet mix. An item (a stereo sample pair) is accepted, then runs twenty steps
// per channel through the single shared multiplier and the registered ring memory
// ports, and then loads the output register once a stalled result has left it.
// The next item is taken while a result waits on the output. After reset the rings
// are swept to zero, one entry a cycle, and no item is accepted until that sweep
// ends; configuration writes are taken at any time. Writing delay_length restarts
// the taps and ring indices.
// depends on scps_pkg, scps_ctrl, scps_dp
`default_nettype none

module stereo_crossfade_pitch_shifter_core #(
    parameter int PITCH_DEPTH = 1024,
    parameter int DELAY_DEPTH = 32768
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_wr_en,
    input  wire  [scps_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire  [scps_pkg::CFG_BITS-1:0]           i_cfg_data,
    input  wire                                     i_valid,
    output logic                                    o_stall,
    input  wire  signed [scps_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  wire  signed [scps_pkg::SAMPLE_BITS-1:0] i_right_sample,
    output logic                                    o_valid,
    input  wire                                     i_stall,
    output logic signed [scps_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [scps_pkg::SAMPLE_BITS-1:0] o_right_out
);

    scps_pkg::t_cmd  cmd;
    scps_pkg::t_stat stat;

    scps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    scps_dp #(
        .PITCH_DEPTH (PITCH_DEPTH),
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out)
    );

endmodule

`default_nettype wire
